// ===== src/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// No dependencies; each macro expects signals clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define AST_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// Condition a implies condition c in the next cycle.
`define AST_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// ===== src/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, status codes, header entry.
// No dependencies.
`timescale 1ns / 1ps
package ffha_pkg;
  localparam int HEAP_UNITS   = 4096;
  localparam int HEADER_UNITS = 3;
  localparam int AW           = $clog2(HEAP_UNITS);
  localparam int SIZE_W       = 15;
  localparam int OFFS_W       = 14;
  localparam int UNITS_W      = AW + 2;
  localparam int NEED_W       = AW + 2;
  localparam logic [AW-1:0] SENTINEL = AW'(HEAP_UNITS - HEADER_UNITS);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_NOFIT   = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic          used;
    logic [AW-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);
endpackage

// ===== src/ffha_ifs.sv =====
// Valid/ready channel interfaces for requests and responses of the allocator.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
interface ffha_req_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] size_bytes;
  logic [OFFS_W-1:0] free_offset;
  modport source (output valid, mode, size_bytes, free_offset, input ready);
  modport sink   (input valid, mode, size_bytes, free_offset, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [OFFS_W-1:0] block_offset;
  modport source (output valid, status, block_offset, input ready);
  modport sink   (input valid, status, block_offset, output ready);
endinterface

// ===== src/ffha_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module ffha_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing, top level.
// Depends on ffha_pkg, ffha_ifs, ffha_ram and assert_macros.svh.
//
// Usage: requests arrive as beats on req (mode 0 allocate size_bytes, mode 1
// free the payload at free_offset). Every request beat yields exactly one
// response beat on rsp with a status and, for a good allocate, the byte offset
// of the payload. Requests are handled one at a time; req.ready is high only
// while the engine is idle.
//
// Sequence: each header visited takes a memory read, then a decision, set by
// the registered read of the header RAM. An allocate walks the blocks, writes
// the split, then rescans for the lowest free block; a free marks its header
// free, scans from unit 0 for the lowest free block, then merges from there.
// Zero-size, no-free-block and out-of-range requests go straight to the answer.
//
// Reset: synchronous, active high. The heap starts as one free block at unit 0
// linked to the used sentinel. Entry 0 reads as its reset value until first
// written, so no clearing pass is needed; the sentinel header is never read.
//
// Stall: the response sits in an output register. A new request is accepted
// while it waits; the engine holds its next answer until the register drains.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  ffha_req_if.sink req,
  ffha_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_DAT, S_A_W2, S_L_RD, S_L_DAT, S_F_RD, S_F_DAT,
    S_M_PRD, S_M_PDAT, S_M_NRD, S_M_NDAT, S_DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      p;             // current header
  logic [AW-1:0]      n;             // neighbor header during a merge
  logic [AW-1:0]      split_q;
  logic [NEED_W-1:0]  need;
  logic [AW-1:0]      lowest_free;
  logic               lowest_free_valid;
  logic               merging;       // the lowest-free scan belongs to a free
  logic               zinit;         // entry 0 still holds its reset value
  logic [AW-1:0]      rd_addr_q;
  logic [1:0]         res_status;
  logic [OFFS_W-1:0]  res_offset;

  logic               we;
  logic [AW-1:0]      waddr;
  entry_t             wdata;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t             e;
  logic [AW-1:0]      nf_p;
  logic [AW-1:0]      fn_n;
  logic               found;
  logic [NEED_W-1:0]  split_w;
  logic [UNITS_W-1:0] units;
  logic [AW-1:0]      f_unit;
  logic [AW:0]        f_hdr;

  // Chain guard: a link that does not point forward or passes the sentinel
  // stands for the sentinel.
  function automatic logic [AW-1:0] follow(input logic [AW-1:0] pos,
                                           input logic [AW-1:0] lnk);
    follow = (lnk <= pos || lnk > SENTINEL) ? SENTINEL : lnk;
  endfunction

  ffha_ram #(.W(ENTRY_W), .D(HEAP_UNITS)) u_hdr_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entry 0 starts linked to the sentinel and free.
  assign e = (rd_addr_q == '0 && zinit) ? entry_t'{used: 1'b0, link: SENTINEL}
                                        : entry_t'(rdata);
  assign nf_p    = follow(p, e.link);
  assign fn_n    = follow(n, e.link);
  assign found   = !e.used && ({2'b00, nf_p - p} >= need);
  assign split_w = NEED_W'(p) + NEED_W'(need) - NEED_W'(HEADER_UNITS);
  // The rounding sum needs one bit more than the size field.
  assign units   = UNITS_W'(({1'b0, req.size_bytes} + (SIZE_W + 1)'(3)) >> 2);
  assign f_unit  = req.free_offset[OFFS_W-1:2];
  assign f_hdr   = {1'b0, f_unit} - (AW + 1)'(HEADER_UNITS);
  assign raddr   = (state == S_M_NRD) ? n : p;

  always_comb begin
    we    = 1'b0;
    waddr = p;
    wdata = entry_t'{used: 1'b0, link: e.link};
    case (state)
      S_A_DAT: begin
        if (found) begin
          we    = 1'b1;
          waddr = split_w[AW-1:0];
          wdata = entry_t'{used: 1'b0, link: nf_p};
        end
      end
      S_A_W2: begin
        we    = 1'b1;
        wdata = entry_t'{used: 1'b1, link: split_q};
      end
      S_F_DAT: begin
        we = 1'b1;
      end
      S_M_NDAT: begin
        if (!e.used) begin
          we    = 1'b1;
          wdata = entry_t'{used: 1'b0, link: fn_n};
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      lowest_free       <= '0;
      lowest_free_valid <= 1'b1;
      merging           <= 1'b0;
      zinit             <= 1'b1;
      rsp.valid         <= 1'b0;
    end else begin
      rd_addr_q <= raddr;
      if (we && waddr == '0) begin
        zinit <= 1'b0;
      end
      // In S_DONE the output register is reloaded or held below.
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            res_offset <= '0;
            res_status <= ST_OK;
            if (req.mode == MODE_ALLOC) begin
              need <= NEED_W'(units) + NEED_W'(2 * HEADER_UNITS);
              p    <= lowest_free;
              if (req.size_bytes == '0) begin
                res_status <= ST_ZERO;
                state      <= S_DONE;
              end else if (!lowest_free_valid) begin
                res_status <= ST_NOFIT;
                state      <= S_DONE;
              end else begin
                state <= S_A_RD;
              end
            end else begin
              p <= f_hdr[AW-1:0];
              if (f_hdr[AW] || f_hdr[AW-1:0] >= SENTINEL) begin
                res_status <= ST_BADFREE;
                state      <= S_DONE;
              end else begin
                state <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: begin
          state <= S_A_DAT;
        end
        S_A_DAT: begin
          if (found) begin
            split_q    <= split_w[AW-1:0];
            res_offset <= {p + AW'(HEADER_UNITS), 2'b00};
            state      <= S_A_W2;
          end else if (nf_p >= SENTINEL) begin
            res_status <= ST_NOFIT;
            state      <= S_DONE;
          end else begin
            p     <= nf_p;
            state <= S_A_RD;
          end
        end
        S_A_W2: begin
          p       <= lowest_free;
          merging <= 1'b0;
          state   <= S_L_RD;
        end
        S_L_RD: begin
          state <= S_L_DAT;
        end
        S_L_DAT: begin
          if (!e.used) begin
            lowest_free       <= p;
            lowest_free_valid <= 1'b1;
            state             <= merging ? S_M_PRD : S_DONE;
          end else if (nf_p >= SENTINEL) begin
            lowest_free       <= '0;
            lowest_free_valid <= 1'b0;
            state             <= S_DONE;
          end else begin
            p     <= nf_p;
            state <= S_L_RD;
          end
        end
        S_F_RD: begin
          state <= S_F_DAT;
        end
        S_F_DAT: begin
          p       <= '0;
          merging <= 1'b1;
          state   <= S_L_RD;
        end
        S_M_PRD: begin
          state <= S_M_PDAT;
        end
        S_M_PDAT: begin
          // A free header looks at its neighbor; a used one is stepped over.
          if (nf_p >= SENTINEL) begin
            state <= S_DONE;
          end else if (e.used) begin
            p     <= nf_p;
            state <= S_M_PRD;
          end else begin
            n     <= nf_p;
            state <= S_M_NRD;
          end
        end
        S_M_NRD: begin
          state <= S_M_NDAT;
        end
        S_M_NDAT: begin
          // A free neighbor is absorbed into p; a used one ends the run.
          if (e.used) begin
            p     <= fn_n;
            state <= (fn_n >= SENTINEL) ? S_DONE : S_M_PRD;
          end else begin
            n     <= fn_n;
            state <= (fn_n >= SENTINEL) ? S_DONE : S_M_NRD;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.block_offset <= res_offset;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `AST_IMPL(ast_idle_no_write, state == S_IDLE, !we)
  `AST_IMPL(ast_lowest_below_sentinel, lowest_free_valid, lowest_free < SENTINEL)
  `AST_NEXT(ast_accept_leaves_idle, req.valid && req.ready, state != S_IDLE)
  `AST_IMPL(ast_merge_write_forward, state == S_M_NDAT && we, n > p)
endmodule
